// ===== design/ajfa_pkg.sv =====
// Shared types and constants for the accelerometer jerk alarm.
// Used by the squaring unit, the square root unit, the alarm tracker and the top level.
// No dependencies.
package ajfa_pkg;

    localparam int AXIS_W   = 16;
    localparam int SUM_W    = 32;
    localparam int RAD_W    = 40;
    localparam int MAG_W    = 20;
    localparam int CNT_W    = 16;
    localparam int SQ_CNT_W = 4;
    localparam int RT_CNT_W = 5;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;
    localparam int ADDR_W     = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [MAG_W-1:0] JERK_THRESHOLD_RESET = 20'd10486;
    localparam logic [CNT_W-1:0] ALARM_SAMPLES_RESET  = 16'd600;
    localparam logic [MAG_W-1:0] MAG_MAX              = 20'd908100;
    localparam logic [CNT_W-1:0] CNT_MAX              = 16'hFFFF;
    localparam logic [SQ_CNT_W-1:0] SQ_LAST_STEP      = 4'd15;
    localparam logic [RT_CNT_W-1:0] RT_LAST_STEP      = 5'd19;

    // Register index, taken from paddr bit 2.
    localparam logic REG_JERK_THRESHOLD = 1'b0;
    localparam logic REG_ALARM_SAMPLES  = 1'b1;

    typedef struct packed {
        logic on;
        logic started;
    } alarm_flags_t;

endpackage

// ===== design/ajfa_sqsum.sv =====
// Bit-serial sum of squares of three signed 16-bit axis values.
// One multiplier bit of every axis is consumed per cycle, until all 16 bits are used.
// Depends on ajfa_pkg.
module ajfa_sqsum
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [ajfa_pkg::AXIS_W-1:0] accel_x,
    input  logic signed [ajfa_pkg::AXIS_W-1:0] accel_y,
    input  logic signed [ajfa_pkg::AXIS_W-1:0] accel_z,
    output logic                              done,
    output logic [ajfa_pkg::SUM_W-1:0]         sum
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [ajfa_pkg::SQ_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ajfa_pkg::SUM_W-1:0]      ax_reg, ay_reg, az_reg;
    logic [ajfa_pkg::SUM_W-1:0]      ax_next, ay_next, az_next;
    logic [ajfa_pkg::AXIS_W-1:0]     bx_reg, by_reg, bz_reg;
    logic [ajfa_pkg::AXIS_W-1:0]     bx_next, by_next, bz_next;
    logic [ajfa_pkg::SUM_W-1:0]      acc_reg, acc_next;
    logic [ajfa_pkg::AXIS_W-1:0]     abs_x, abs_y, abs_z;
    logic [ajfa_pkg::SUM_W-1:0]      term_x, term_y, term_z;

    // Magnitudes fit 16 unsigned bits, including the most negative value.
    assign abs_x = accel_x[ajfa_pkg::AXIS_W-1] ? (~accel_x + 16'd1) : accel_x;
    assign abs_y = accel_y[ajfa_pkg::AXIS_W-1] ? (~accel_y + 16'd1) : accel_y;
    assign abs_z = accel_z[ajfa_pkg::AXIS_W-1] ? (~accel_z + 16'd1) : accel_z;

    assign term_x = bx_reg[0] ? ax_reg : '0;
    assign term_y = by_reg[0] ? ay_reg : '0;
    assign term_z = bz_reg[0] ? az_reg : '0;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        ax_next   = ax_reg;
        ay_next   = ay_reg;
        az_next   = az_reg;
        bx_next   = bx_reg;
        by_next   = by_reg;
        bz_next   = bz_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            ax_next   = {16'd0, abs_x};
            ay_next   = {16'd0, abs_y};
            az_next   = {16'd0, abs_z};
            bx_next   = abs_x;
            by_next   = abs_y;
            bz_next   = abs_z;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + term_x + term_y + term_z;
            ax_next  = {ax_reg[ajfa_pkg::SUM_W-2:0], 1'b0};
            ay_next  = {ay_reg[ajfa_pkg::SUM_W-2:0], 1'b0};
            az_next  = {az_reg[ajfa_pkg::SUM_W-2:0], 1'b0};
            bx_next  = {1'b0, bx_reg[ajfa_pkg::AXIS_W-1:1]};
            by_next  = {1'b0, by_reg[ajfa_pkg::AXIS_W-1:1]};
            bz_next  = {1'b0, bz_reg[ajfa_pkg::AXIS_W-1:1]};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == ajfa_pkg::SQ_LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        az_reg  <= az_next;
        bx_reg  <= bx_next;
        by_reg  <= by_next;
        bz_reg  <= bz_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

// ===== design/ajfa_isqrt.sv =====
// Digit-serial floor square root of the sum of squares scaled by 256.
// Two radicand bits enter per cycle, one root bit leaves, until all 20 root bits are formed.
// Depends on ajfa_pkg.
module ajfa_isqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ajfa_pkg::SUM_W-1:0]   sum,
    output logic                         done,
    output logic [ajfa_pkg::MAG_W-1:0]   root
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [ajfa_pkg::RT_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ajfa_pkg::RAD_W-1:0]      rad_reg, rad_next;
    logic [ajfa_pkg::MAG_W:0]        rem_reg, rem_next;
    logic [ajfa_pkg::MAG_W-1:0]      root_reg, root_next;
    logic [ajfa_pkg::MAG_W+2:0]      rem_sh;
    logic [ajfa_pkg::MAG_W+1:0]      trial;
    logic [ajfa_pkg::MAG_W+2:0]      rem_sub;

    assign rem_sh  = {rem_reg, rad_reg[ajfa_pkg::RAD_W-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign rem_sub = rem_sh - {1'b0, trial};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = {sum, 8'd0};
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[ajfa_pkg::RAD_W-3:0], 2'b00};
            if (rem_sh >= {1'b0, trial})
            begin
                rem_next  = rem_sub[ajfa_pkg::MAG_W:0];
                root_next = {root_reg[ajfa_pkg::MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[ajfa_pkg::MAG_W:0];
                root_next = {root_reg[ajfa_pkg::MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == ajfa_pkg::RT_LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== design/ajfa_alarm.sv =====
// Jerk threshold test and alarm duration counter.
// Flags are formed from the current state and the new magnitude; state moves on commit.
// Depends on ajfa_pkg.
module ajfa_alarm
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         commit,
    input  logic [ajfa_pkg::MAG_W-1:0]   magnitude,
    input  logic [ajfa_pkg::MAG_W-1:0]   jerk_threshold,
    input  logic [ajfa_pkg::CNT_W-1:0]   alarm_samples,
    output ajfa_pkg::alarm_flags_t       flags
);

    logic [ajfa_pkg::MAG_W-1:0] last_mag_reg;
    logic                       active_reg, active_next;
    logic [ajfa_pkg::CNT_W-1:0] elapsed_reg, elapsed_next;
    logic [ajfa_pkg::MAG_W-1:0] diff;
    logic                       trigger;
    logic                       active_mid;

    assign diff = (magnitude >= last_mag_reg) ? (magnitude - last_mag_reg)
                                              : (last_mag_reg - magnitude);
    assign trigger = !active_reg && (diff > jerk_threshold);

    always_comb
    begin
        active_mid   = active_reg;
        elapsed_next = elapsed_reg;
        priority if (trigger)
        begin
            active_mid   = 1'b1;
            elapsed_next = '0;
        end
        else if (active_reg && (elapsed_reg != ajfa_pkg::CNT_MAX))
        begin
            elapsed_next = elapsed_reg + 16'd1;
        end
        // A clear on this sample never re-arms the trigger until the next one.
        active_next = active_mid && (elapsed_next < alarm_samples);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_mag_reg <= '0;
            active_reg   <= 1'b0;
            elapsed_reg  <= '0;
        end
        else if (commit)
        begin
            last_mag_reg <= magnitude;
            active_reg   <= active_next;
            elapsed_reg  <= elapsed_next;
        end
    end

    assign flags.on      = active_next;
    assign flags.started = trigger;

endmodule

// ===== design/accel_jerk_fall_alarm_core.sv =====
// Accelerometer jerk alarm, top level: stream ports, APB registers and sequencing.
// Each sample passes through the serial squaring unit, then the square root unit, then the
// output register; no new sample is taken until the previous result is committed.
// Reset (rst_n, asynchronous, active low) clears the alarm, the stored magnitude and the
// registers to their defaults. Depends on ajfa_pkg, ajfa_sqsum, ajfa_isqrt and ajfa_alarm.
module accel_jerk_fall_alarm_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ajfa_pkg::IN_DATA_W-1:0]      s_tdata,   // accel_x, accel_y, accel_z
    // Output stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ajfa_pkg::OUT_DATA_W-1:0]     m_tdata,   // alarm_on, alarm_started,
                                                           // magnitude, 2 zero pad bits
    // APB configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ajfa_pkg::ADDR_W-1:0]         paddr,
    input  logic [ajfa_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ajfa_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    // One-hot sequencer: wait for a sample, square, take the root, hold a finished
    // result while the output register is still occupied.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SQUARE = 4'b0010,
        ST_ROOT   = 4'b0100,
        ST_HOLD   = 4'b1000
    } state_t;

    state_t                            state_reg, state_next;
    logic [ajfa_pkg::MAG_W-1:0]        jerk_threshold_reg;
    logic [ajfa_pkg::CNT_W-1:0]        alarm_samples_reg;
    logic                              m_tvalid_reg;
    logic [ajfa_pkg::OUT_DATA_W-1:0]   m_tdata_reg;

    logic                              accept;
    logic                              out_free;
    logic                              commit;
    logic                              cfg_write;
    logic                              sq_done;
    logic [ajfa_pkg::SUM_W-1:0]        sq_sum;
    logic                              rt_done;
    logic [ajfa_pkg::MAG_W-1:0]        magnitude;
    ajfa_pkg::alarm_flags_t            flags;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // The output register frees up in the same cycle its transfer completes.
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = ((state_reg == ST_ROOT) && rt_done && out_free)
                   || ((state_reg == ST_HOLD) && out_free);

    ajfa_sqsum u_sqsum
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .accel_x (s_tdata[15:0]),
        .accel_y (s_tdata[31:16]),
        .accel_z (s_tdata[47:32]),
        .done    (sq_done),
        .sum     (sq_sum)
    );

    ajfa_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_done),
        .sum   (sq_sum),
        .done  (rt_done),
        .root  (magnitude)
    );

    // The root result register holds its value until the next sample starts, so a
    // result parked in the hold state still sees the right magnitude.
    ajfa_alarm u_alarm
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .commit         (commit),
        .magnitude      (magnitude),
        .jerk_threshold (jerk_threshold_reg),
        .alarm_samples  (alarm_samples_reg),
        .flags          (flags)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (sq_done)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (rt_done)
                begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            m_tdata_reg <= {2'b00, magnitude, flags.started, flags.on};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Configuration registers. Bit 2 of the address picks the register; writes land on
    // the access cycle of the transfer.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jerk_threshold_reg <= ajfa_pkg::JERK_THRESHOLD_RESET;
            alarm_samples_reg  <= ajfa_pkg::ALARM_SAMPLES_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                ajfa_pkg::REG_JERK_THRESHOLD:
                begin
                    jerk_threshold_reg <= pwdata[ajfa_pkg::MAG_W-1:0];
                end
                ajfa_pkg::REG_ALARM_SAMPLES:
                begin
                    alarm_samples_reg <= pwdata[ajfa_pkg::CNT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ajfa_pkg::REG_JERK_THRESHOLD:
            begin
                prdata = {12'd0, jerk_threshold_reg};
            end
            ajfa_pkg::REG_ALARM_SAMPLES:
            begin
                prdata = {16'd0, alarm_samples_reg};
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // A sample that triggers only shows the alarm off when the duration is zero.
    a_started_duration: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && flags.started) |-> (flags.on == (alarm_samples_reg != '0)))
        else $error("alarm start and duration register disagree");

    // Once a sample is taken, no further sample enters until it has been finished.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("second sample accepted while one is in progress");

    // The root of the largest possible radicand bounds every magnitude sent out.
    a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[21:2] <= ajfa_pkg::MAG_MAX))
        else $error("magnitude above its possible maximum");

endmodule

// ===== sim/jerk_alarm_checker.sv =====
// Checker for the accelerometer jerk alarm: watches the APB port and both streams,
// predicts every result from its own copy of the registers and state, and compares.
// Depends on ajfa_pkg.
module jerk_alarm_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ajfa_pkg::IN_DATA_W-1:0]  s_tdata,   // accel_x, accel_y, accel_z
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ajfa_pkg::OUT_DATA_W-1:0] m_tdata,   // alarm_on, alarm_started,
                                                       // magnitude, pad
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ajfa_pkg::ADDR_W-1:0]     paddr,
    input  logic [ajfa_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [ajfa_pkg::APB_DATA_W-1:0] prdata,
    input  logic                            pready,
    output int                              fail_count,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        ajfa_pkg::alarm_flags_t     flags;
        logic [ajfa_pkg::MAG_W-1:0] magnitude;
    } alarm_result_t;

    alarm_result_t              expected_results[$];
    logic [ajfa_pkg::MAG_W-1:0] threshold_copy;
    logic [ajfa_pkg::CNT_W-1:0] duration_copy;
    logic [ajfa_pkg::MAG_W-1:0] prev_magnitude;
    logic                       alarm_live;
    logic [ajfa_pkg::CNT_W-1:0] alarm_count;

    // Floor square root, built one result bit at a time from the top.
    function automatic logic [ajfa_pkg::MAG_W-1:0] floor_root(
        input longint unsigned radicand);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = ajfa_pkg::MAG_W - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        return root[ajfa_pkg::MAG_W-1:0];
    endfunction

    // Magnitude in Q.4: sqrt(256 * (x^2 + y^2 + z^2)).
    function automatic logic [ajfa_pkg::MAG_W-1:0] sample_magnitude(
        input logic [ajfa_pkg::IN_DATA_W-1:0] data);
        longint          ax;
        longint          ay;
        longint          az;
        longint unsigned energy;
        ax = longint'($signed(data[ajfa_pkg::AXIS_W-1:0]));
        ay = longint'($signed(data[2*ajfa_pkg::AXIS_W-1:ajfa_pkg::AXIS_W]));
        az = longint'($signed(data[3*ajfa_pkg::AXIS_W-1:2*ajfa_pkg::AXIS_W]));
        energy = ax * ax + ay * ay + az * az;
        return floor_root(energy << 8);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [ajfa_pkg::MAG_W-1:0]      mag;
        logic [ajfa_pkg::MAG_W-1:0]      change;
        logic                            started;
        logic [ajfa_pkg::APB_DATA_W-1:0] reg_value;
        alarm_result_t                   want;
        alarm_result_t                   got;
        if (!rst_n)
        begin
            expected_results.delete();
            threshold_copy = ajfa_pkg::JERK_THRESHOLD_RESET;
            duration_copy  = ajfa_pkg::ALARM_SAMPLES_RESET;
            prev_magnitude = '0;
            alarm_live     = 1'b0;
            alarm_count    = '0;
            fail_count     = 0;
            pending        = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == ajfa_pkg::REG_JERK_THRESHOLD)
                        threshold_copy = pwdata[ajfa_pkg::MAG_W-1:0];
                    else
                        duration_copy = pwdata[ajfa_pkg::CNT_W-1:0];
                end
                else
                begin
                    if (paddr[2] == ajfa_pkg::REG_JERK_THRESHOLD)
                        reg_value = ajfa_pkg::APB_DATA_W'(threshold_copy);
                    else
                        reg_value = ajfa_pkg::APB_DATA_W'(duration_copy);
                    if (prdata !== reg_value)
                    begin
                        $error("prdata mismatch at paddr %0d: expected %0d, got %0d",
                               paddr, reg_value, prdata);
                        fail_count++;
                    end
                end
            end

            // A result can only belong to an older sample, so it is matched first.
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no sample waiting: m_tdata %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    got  = {m_tdata[0], m_tdata[1], m_tdata[ajfa_pkg::MAG_W+1:2]};
                    if (got.flags.on !== want.flags.on)
                    begin
                        $error("alarm_on mismatch: expected %0d, got %0d",
                               want.flags.on, got.flags.on);
                        fail_count++;
                    end
                    if (got.flags.started !== want.flags.started)
                    begin
                        $error("alarm_started mismatch: expected %0d, got %0d",
                               want.flags.started, got.flags.started);
                        fail_count++;
                    end
                    if (got.magnitude !== want.magnitude)
                    begin
                        $error("magnitude mismatch: expected %0d, got %0d",
                               want.magnitude, got.magnitude);
                        fail_count++;
                    end
                    if (m_tdata[ajfa_pkg::OUT_DATA_W-1:ajfa_pkg::MAG_W+2] !== '0)
                    begin
                        $error("pad mismatch: expected 0, got %0d",
                               m_tdata[ajfa_pkg::OUT_DATA_W-1:ajfa_pkg::MAG_W+2]);
                        fail_count++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                mag = sample_magnitude(s_tdata);
                change = (mag >= prev_magnitude) ? mag - prev_magnitude
                                                 : prev_magnitude - mag;
                prev_magnitude = mag;
                started = 1'b0;
                if (!alarm_live && change > threshold_copy)
                begin
                    alarm_live  = 1'b1;
                    alarm_count = '0;
                    started     = 1'b1;
                end
                else if (alarm_live && alarm_count != ajfa_pkg::CNT_MAX)
                    alarm_count = alarm_count + ajfa_pkg::CNT_W'(1);
                // A clear on this sample never restarts on the same sample.
                if (alarm_live && alarm_count >= duration_copy)
                    alarm_live = 1'b0;
                want.flags.on      = alarm_live;
                want.flags.started = started;
                want.magnitude     = mag;
                expected_results.push_back(want);
            end
            pending = expected_results.size();
        end
    end

endmodule

// ===== sim/accel_jerk_fall_alarm_core_test.sv =====
// Testbench top for the accelerometer jerk alarm: clock, reset, stimulus and verdict.
// Depends on ajfa_pkg, jerk_alarm_checker and the accel_jerk_fall_alarm_core RTL.
module accel_jerk_fall_alarm_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles from an input transfer to its result, used to size the drain wait.
    localparam int LATENCY = 38;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 72;
    localparam logic [ajfa_pkg::ADDR_W-1:0] ADDR_THRESHOLD =
        {ajfa_pkg::REG_JERK_THRESHOLD, 2'b00};
    localparam logic [ajfa_pkg::ADDR_W-1:0] ADDR_DURATION  =
        {ajfa_pkg::REG_ALARM_SAMPLES, 2'b00};

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [ajfa_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [ajfa_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [ajfa_pkg::ADDR_W-1:0]     paddr;
    logic [ajfa_pkg::APB_DATA_W-1:0] pwdata;
    logic [ajfa_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    int                              fail_count;
    int                              pending;

    // When set, neither side inserts idle cycles, so samples go back to back.
    logic                            idle_free;

    accel_jerk_fall_alarm_core u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    jerk_alarm_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
        clk = 1'b0;

    always #10 clk = ~clk;

    // Hard limit on the run; a correct run finishes well inside it.
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: before each result it holds tready low for a random number of
    // cycles, then keeps it high until the transfer happens.
    initial
    begin : result_sink
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = idle_free ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
            @(negedge clk);
        end
    end

    // One sample transfer. Starts and ends at a falling edge; tvalid stays high
    // into the next call when that call draws no gap.
    task automatic send_sample(input logic [ajfa_pkg::AXIS_W-1:0] ax,
                               input logic [ajfa_pkg::AXIS_W-1:0] ay,
                               input logic [ajfa_pkg::AXIS_W-1:0] az);
        int gap;
        gap = idle_free ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {az, ay, ax};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!(s_tvalid && s_tready))
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stops the sender until every expected result has arrived, then lets the
    // pipeline settle before returning.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [ajfa_pkg::ADDR_W-1:0] addr,
                              input logic [ajfa_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drains the pipeline, writes both registers and reads them back; the checker compares the reads.
    task automatic apply_setting(input logic [ajfa_pkg::MAG_W-1:0] threshold,
                                 input logic [ajfa_pkg::CNT_W-1:0] duration);
        wait_drained();
        apb_access(1'b1, ADDR_THRESHOLD, ajfa_pkg::APB_DATA_W'(threshold));
        apb_access(1'b1, ADDR_DURATION, ajfa_pkg::APB_DATA_W'(duration));
        apb_access(1'b0, ADDR_THRESHOLD, '0);
        apb_access(1'b0, ADDR_DURATION, '0);
    endtask

    // An axis value scattered around a centre, clamped to the 16-bit range.
    function automatic logic [ajfa_pkg::AXIS_W-1:0] jitter(input int centre,
                                                           input int spread);
        int v;
        v = centre + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[ajfa_pkg::AXIS_W-1:0];
    endfunction

    initial
    begin : stimulus
        int                         base_x;
        int                         base_y;
        int                         base_z;
        int                         noise;
        int                         pick;
        logic [ajfa_pkg::MAG_W-1:0] threshold;
        logic [ajfa_pkg::CNT_W-1:0] duration;

        rst_n     = 1'b0;
        idle_free = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values read back first.
        apb_access(1'b0, ADDR_THRESHOLD, '0);
        apb_access(1'b0, ADDR_DURATION, '0);

        // Default registers: the stored magnitude starts at zero, so the first large
        // step triggers. Axis extremes follow while the long alarm is running.
        send_sample(16'd0, 16'd0, 16'd0);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h8000, 16'd0, 16'd0);
        send_sample(16'd0, 16'h7FFF, 16'd0);
        send_sample(16'd0, 16'd0, 16'h8000);
        send_sample(16'd1, 16'hFFFF, 16'd1);
        send_sample(16'hFFFF, 16'd0, 16'd0);

        // Zero duration: a trigger clears on the same sample. The write also lands
        // while the previous alarm is still on, which must clear it next sample.
        apply_setting(20'd0, 16'd0);
        send_sample(16'd100, 16'd0, 16'd0);
        send_sample(16'd100, 16'd0, 16'd0);
        send_sample(16'd16384, 16'd0, 16'd0);

        // Largest threshold: even the biggest possible step never triggers.
        apply_setting(20'hFFFFF, 16'd1);
        send_sample(16'd0, 16'd0, 16'd0);
        send_sample(16'h8000, 16'h8000, 16'h8000);

        // One-sample alarm: trigger, clear on the next sample, then trigger again.
        apply_setting(20'd5000, 16'd1);
        send_sample(16'd0, 16'd0, 16'd0);
        send_sample(16'd16384, 16'd0, 16'd0);
        send_sample(16'd16384, 16'd0, 16'd0);
        send_sample(16'd0, 16'd0, 16'd0);

        // A step exactly equal to the threshold does not trigger; 1 g is 262144 in Q.4.
        apply_setting(20'd262144, 16'd3);
        send_sample(16'd0, 16'd0, 16'd0);
        send_sample(16'd16384, 16'd0, 16'd0);
        send_sample(16'd16385, 16'd0, 16'd0);
        send_sample(16'd0, 16'd0, 16'd0);

        // Random phases: mostly a quiet sensor at rest with small noise, broken by
        // sudden jolts, plus some fully random samples.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    threshold = '0;
                    duration  = 16'd1;
                end
                1:
                begin
                    threshold = 20'hFFFFF;
                    duration  = 16'hFFFF;
                end
                2:
                begin
                    threshold = ajfa_pkg::MAG_W'($urandom_range(2000, 40000));
                    duration  = 16'd0;
                end
                3:
                begin
                    threshold = ajfa_pkg::MAG_W'($urandom_range(2000, 40000));
                    duration  = 16'hFFFF;
                end
                default:
                begin
                    threshold = ajfa_pkg::MAG_W'($urandom_range(500, 60000));
                    duration  = ajfa_pkg::CNT_W'($urandom_range(1, 30));
                end
            endcase
            apply_setting(threshold, duration);
            idle_free = (phase % 4 == 2);
            base_x = int'($urandom_range(0, 32767)) - 16384;
            base_y = int'($urandom_range(0, 32767)) - 16384;
            base_z = int'($urandom_range(0, 32767)) - 16384;
            noise  = $urandom_range(0, 300);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    send_sample(ajfa_pkg::AXIS_W'($urandom()), ajfa_pkg::AXIS_W'($urandom()),
                                ajfa_pkg::AXIS_W'($urandom()));
                else if (pick < 27)
                    send_sample(jitter(base_x, 20000), jitter(base_y, 20000),
                                jitter(base_z, 20000));
                else
                    send_sample(jitter(base_x, noise), jitter(base_y, noise),
                                jitter(base_z, noise));
                // Now and then the sender holds off until the pipeline is empty.
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        if (pending != 0)
            $error("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
